[hw/rtl/lru_pkg.sv]
package lru_pkg;

  // Number of resident page slots
  localparam int CAPACITY  = 16;
  // Stored tag width (page numbers are taken modulo 2^PAGE_BITS)
  localparam int PAGE_BITS = 20;
  // Fixed widths of the channel fields
  localparam int PAGE_W    = 20;
  localparam int OCC_W     = 5;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W = SLOT_W;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [PAGE_BITS-1:0] tag_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the accepted page number
    logic lookup;  // compare against all slots and register the outcome
    logic commit;  // update slots and load the result register
  } lru_cmd_t;

endpackage

[hw/rtl/lru_if.sv]
interface lru_in_if
  import lru_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_out_if
  import lru_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic              evicted;
  logic [PAGE_W-1:0] victim_page;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output hit, output evicted, output victim_page,
                  output occupancy, input ready);
  modport sink   (input valid, input hit, input evicted, input victim_page,
                  input occupancy, output ready);
endinterface

[hw/rtl/lru_ctrl.sv]
module lru_ctrl
  import lru_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lru_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Decode commands from the current state
  always_comb begin
    cmd.load   = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.lookup = (state_r == S_LOOK);
    cmd.commit = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  end

  // Advance the sequence: accept, look up, commit into the result register
  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt    = S_LOOK;
          in_ready_nxt = 1'b0;
        end
      end
      S_LOOK: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          in_ready_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/lru_dp.sv]
module lru_dp
  import lru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lru_cmd_t          cmd,
  input  logic [PAGE_W-1:0] in_page_number,
  output logic              out_hit,
  output logic              out_evicted,
  output logic [PAGE_W-1:0] out_victim_page,
  output logic [OCC_W-1:0]  out_occupancy
);

  // Slot state
  tag_t                tag_r   [CAPACITY];
  rank_t               rank_r  [CAPACITY];
  rank_t               rank_nxt[CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  cnt_t                count_r, count_nxt;

  // Current access and registered lookup outcome
  tag_t  page_r;
  logic  hit_r;
  slot_t hit_idx_r, free_idx_r, vict_idx_r;
  rank_t hit_rank_r;

  // Result register
  logic              res_hit_r, res_evicted_r;
  logic [PAGE_W-1:0] res_victim_r;
  logic [OCC_W-1:0]  res_occ_r;

  // Lookup: parallel tag compare plus lowest-index priority picks
  logic  hit_any;
  slot_t hit_idx, free_idx, vict_idx;

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    vict_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == page_r)) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
      end
      // Ranks form a permutation, so the oldest slot holds the top rank
      if (valid_r[i] && (rank_r[i] == RANK_W'(CAPACITY - 1))) begin
        vict_idx = SLOT_W'(i);
      end
    end
  end

  // Commit: age ranks; on a miss place the page and, below full, count it
  logic full;
  slot_t tgt_idx;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign tgt_idx = full ? vict_idx_r : free_idx_r;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (hit_r) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      rank_nxt[hit_idx_r] = '0;
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      rank_nxt[tgt_idx]  = '0;
      valid_nxt[tgt_idx] = 1'b1;
      if (!full) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // Control-side slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // Payload: page, lookup outcome, tags and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= PAGE_BITS'(in_page_number);
    end
    if (cmd.lookup) begin
      hit_r      <= hit_any;
      hit_idx_r  <= hit_idx;
      free_idx_r <= free_idx;
      vict_idx_r <= vict_idx;
      hit_rank_r <= rank_r[hit_idx];
    end
    if (cmd.commit) begin
      if (!hit_r) begin
        tag_r[tgt_idx] <= page_r;
      end
      res_hit_r     <= hit_r;
      res_evicted_r <= !hit_r && full;
      res_victim_r  <= (!hit_r && full) ? PAGE_W'(tag_r[vict_idx_r]) : '0;
      res_occ_r     <= OCC_W'(count_nxt);
    end
  end

  assign out_hit         = res_hit_r;
  assign out_evicted     = res_evicted_r;
  assign out_victim_page = res_victim_r;
  assign out_occupancy   = res_occ_r;

endmodule

[hw/rtl/lru_page_replacement.sv]
// Fully associative LRU page tracker with CAPACITY slots. Each input beat is one
// page access; each access yields exactly one result beat with the hit flag, the
// eviction flag, the evicted page (zero when none) and the resident count after
// the access. One access is in flight at a time. The page is captured at the
// accepting edge; then a parallel compare of all slot tags is registered with
// the priority picks, and then the rank and tag update loads the result
// register. A new access is accepted in the cycle after the result is loaded,
// while that result still waits to be taken, so no access is accepted before
// the last one has committed. A result held back by the receiver stalls the
// update of the access behind it, and with it the input. The tag store is not
// cleared at reset; only valid slots are ever compared or reported.
module lru_page_replacement
  import lru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  lru_in_if.sink           in_ch,
  lru_out_if.source        out_ch
);

  lru_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  lru_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_page_number  (in_ch.page_number),
    .out_hit         (out_ch.hit),
    .out_evicted     (out_ch.evicted),
    .out_victim_page (out_ch.victim_page),
    .out_occupancy   (out_ch.occupancy)
  );

endmodule

[hw/rtl/lru_checker.sv]
module lru_checker
  import lru_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_hit,
  input logic              out_evicted,
  input logic [PAGE_W-1:0] out_victim_page,
  input logic [OCC_W-1:0]  out_occupancy
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_evicted)
      && $stable(out_victim_page) && $stable(out_occupancy))
    else $error("result beat changed while stalled");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction in one result");

  // Eviction only happens when all slots are resident
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_occupancy == OCC_W'(CAPACITY))
    else $error("eviction below full occupancy");

  // Victim reads zero when nothing was evicted
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_victim_page == '0)
    else $error("victim page nonzero without eviction");

  // One access in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second access accepted while one is in flight");

endmodule

bind lru_page_replacement lru_checker u_lru_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit         (out_ch.hit),
  .out_evicted     (out_ch.evicted),
  .out_victim_page (out_ch.victim_page),
  .out_occupancy   (out_ch.occupancy)
);
